// File: sv/pid_caw_pkg.sv
// ----------------------------------------------------------------------------
// pid_caw_pkg
// Shared constants for the clamped PID controller: configuration register
// indexes and the width of the index field.
// ----------------------------------------------------------------------------
package pid_caw_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 2'd0,
        CFG_DERIV_GAIN  = 2'd1,
        CFG_INTEG_GAIN  = 2'd2,
        CFG_ANTI_WINDUP = 2'd3
    } t_cfg_idx;

endpackage

// File: sv/pid_caw_terms.sv
// ----------------------------------------------------------------------------
// pid_caw_terms
// Product stage: forms the P and I terms and the saturated D term from the
// registered error sample, the previous error and the gains, and registers them.
// ----------------------------------------------------------------------------
module pid_caw_terms #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [DATA_WIDTH-1:0]   i_err,
    input  logic signed [DATA_WIDTH-1:0]   i_prev_err,
    input  logic        [DATA_WIDTH-1:0]   i_prop_gain,
    input  logic        [DATA_WIDTH-1:0]   i_deriv_gain,
    input  logic        [DATA_WIDTH-1:0]   i_integ_gain,
    output logic signed [2*DATA_WIDTH-1:0] o_p_term,
    output logic signed [2*DATA_WIDTH-1:0] o_d_term,
    output logic signed [2*DATA_WIDTH-1:0] o_i_term
);

    localparam int AW = 2 * DATA_WIDTH;

    logic signed [DATA_WIDTH:0]     err_diff;
    logic signed [AW:0]             p_prod;
    logic signed [AW:0]             i_prod;
    logic signed [AW+1:0]           d_prod;
    logic signed [AW-1:0]           d_sat;
    logic signed [AW-1:0]           r_p_term;
    logic signed [AW-1:0]           r_d_term;
    logic signed [AW-1:0]           r_i_term;

    // P and I products always fit the accumulator; D can exceed it.
    assign err_diff = {i_err[DATA_WIDTH-1], i_err} - {i_prev_err[DATA_WIDTH-1], i_prev_err};
    assign p_prod   = i_err * $signed({1'b0, i_prop_gain});
    assign i_prod   = i_err * $signed({1'b0, i_integ_gain});
    assign d_prod   = err_diff * $signed({1'b0, i_deriv_gain});

    always_comb begin
        if ((d_prod[AW+1] == d_prod[AW]) && (d_prod[AW] == d_prod[AW-1])) begin
            d_sat = d_prod[AW-1:0];
        end else if (d_prod[AW+1]) begin
            d_sat = {1'b1, {(AW-1){1'b0}}};
        end else begin
            d_sat = {1'b0, {(AW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_term <= p_prod[AW-1:0];
            r_d_term <= d_sat;
            r_i_term <= i_prod[AW-1:0];
        end
    end

    assign o_p_term = r_p_term;
    assign o_d_term = r_d_term;
    assign o_i_term = r_i_term;

endmodule

// File: sv/pid_with_clamp_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_with_clamp_antiwindup
// Discrete PID step with per-transaction output limits and optional
// anti-windup rewrite of the saturated Q24.8 integral.
// An input transaction passes the input, product, P+D and clamp register stages.
// Throughput: one transaction per cycle while the output is not stalled; the
// integral update, sum, clamp and anti-windup rewrite close within the last stage.
// The whole pipeline holds while a finished result is stalled.
// Synchronous active-low reset clears gains, previous error and integral.
// ----------------------------------------------------------------------------
module pid_with_clamp_antiwindup #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]         i_err_sample,
    input  logic signed [DATA_WIDTH-1:0]         i_upper_limit,
    input  logic signed [DATA_WIDTH-1:0]         i_lower_limit,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [DATA_WIDTH-1:0]         o_drive_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pid_caw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [DATA_WIDTH-1:0]                i_cfg_data
);

    localparam int AW = 2 * DATA_WIDTH;
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    function automatic logic signed [AW-1:0] sat_add(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] b
    );
        logic signed [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] != s[AW-1]) begin
            return s[AW] ? ACC_MIN : ACC_MAX;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] sat_sub(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] b
    );
        logic signed [AW:0] s;
        s = {a[AW-1], a} - {b[AW-1], b};
        if (s[AW] != s[AW-1]) begin
            return s[AW] ? ACC_MIN : ACC_MAX;
        end
        return s[AW-1:0];
    endfunction

    logic                          en;

    logic [DATA_WIDTH-1:0]         r_prop_gain;
    logic [DATA_WIDTH-1:0]         r_deriv_gain;
    logic [DATA_WIDTH-1:0]         r_integ_gain;
    logic                          r_anti_windup;

    logic                          r_s1_valid;
    logic signed [DATA_WIDTH-1:0]  r_s1_err;
    logic signed [DATA_WIDTH-1:0]  r_s1_up;
    logic signed [DATA_WIDTH-1:0]  r_s1_lo;
    logic signed [DATA_WIDTH-1:0]  r_prev_err;

    logic                          r_s2_valid;
    logic signed [DATA_WIDTH-1:0]  r_s2_up;
    logic signed [DATA_WIDTH-1:0]  r_s2_lo;
    logic signed [AW-1:0]          s2_p;
    logic signed [AW-1:0]          s2_d;
    logic signed [AW-1:0]          s2_i;

    logic                          r_s3_valid;
    logic signed [AW-1:0]          r_s3_p;
    logic signed [AW-1:0]          r_s3_d;
    logic signed [AW-1:0]          r_s3_pd;
    logic signed [AW-1:0]          r_s3_i;
    logic signed [AW-1:0]          r_s3_up;
    logic signed [AW-1:0]          r_s3_lo;

    logic signed [AW-1:0]          r_integ;
    logic signed [AW-1:0]          n_integ;
    logic signed [AW-1:0]          integ_acc;
    logic signed [AW-1:0]          sum;
    logic signed [AW-1:0]          cl_hi;
    logic signed [AW-1:0]          cl;

    logic                          r_out_valid;
    logic signed [DATA_WIDTH-1:0]  r_drive_out;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_drive_out = r_drive_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_deriv_gain  <= '0;
            r_integ_gain  <= '0;
            r_anti_windup <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (pid_caw_pkg::t_cfg_idx'(i_cfg_index))
                pid_caw_pkg::CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                pid_caw_pkg::CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data;
                pid_caw_pkg::CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data;
                pid_caw_pkg::CFG_ANTI_WINDUP: r_anti_windup <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_prev_err <= '0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
            if (r_s1_valid) begin
                r_prev_err <= r_s1_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_err <= i_err_sample;
            r_s1_up  <= i_upper_limit;
            r_s1_lo  <= i_lower_limit;
        end
    end

    // Stage 2: products
    pid_caw_terms #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_terms (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_err        (r_s1_err),
        .i_prev_err   (r_prev_err),
        .i_prop_gain  (r_prop_gain),
        .i_deriv_gain (r_deriv_gain),
        .i_integ_gain (r_integ_gain),
        .o_p_term     (s2_p),
        .o_d_term     (s2_d),
        .o_i_term     (s2_i)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_up <= r_s1_up;
            r_s2_lo <= r_s1_lo;
        end
    end

    // Stage 3: P+D and limits in accumulator format
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_p  <= s2_p;
            r_s3_d  <= s2_d;
            r_s3_pd <= sat_add(s2_p, s2_d);
            r_s3_i  <= s2_i;
            r_s3_up <= {{DATA_WIDTH{r_s2_up[DATA_WIDTH-1]}}, r_s2_up} <<< FRAC_BITS;
            r_s3_lo <= {{DATA_WIDTH{r_s2_lo[DATA_WIDTH-1]}}, r_s2_lo} <<< FRAC_BITS;
        end
    end

    // Stage 4: integral update, clamp, anti-windup
    always_comb begin
        integ_acc = sat_add(r_integ, r_s3_i);
        sum       = sat_add(r_s3_pd, integ_acc);
        cl_hi     = (sum > r_s3_up) ? r_s3_up : sum;
        cl        = (cl_hi < r_s3_lo) ? r_s3_lo : cl_hi;
        n_integ   = r_anti_windup ? sat_sub(sat_sub(cl, r_s3_p), r_s3_d) : integ_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s3_valid;
            if (r_s3_valid) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drive_out <= cl[FRAC_BITS +: DATA_WIDTH];
        end
    end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clamped PID controller. A scoreboard class
// tracks the gains, previous error and saturating Q24.8 integral, predicts
// drive_out for every accepted transaction and checks each result in order.
// Directed steps cover zero and full-scale gains, error extremes, term and
// integral saturation, crossed and equal limits and anti-windup; random steps
// then run under eight gain settings, most with random valid gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  DW          = 16;
    localparam int  FB          = 8;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  SETTLE_CYC  = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [DW-1:0] i_err_sample;
    logic signed [DW-1:0] i_upper_limit;
    logic signed [DW-1:0] i_lower_limit;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [DW-1:0] o_drive_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [pid_caw_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [DW-1:0]        i_cfg_data;

    bit          gaps_on;
    int unsigned cycles;
    int unsigned n_settings;

    pid_with_clamp_antiwindup #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_err_sample  (i_err_sample),
        .i_upper_limit (i_upper_limit),
        .i_lower_limit (i_lower_limit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive_out   (o_drive_out),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    class pid_scoreboard;
        longint               kp = 0;
        longint               kd = 0;
        longint               ki = 0;
        bit                   windup_guard = 0;
        longint               last_err = 0;
        longint               integ_acc = 0;
        logic signed [DW-1:0] drive_q[$];
        int unsigned          n_steps = 0;
        int unsigned          n_checked = 0;
        int unsigned          n_errors = 0;
        int unsigned          n_clamped = 0;
        int unsigned          n_crossed = 0;
        int unsigned          n_guarded = 0;

        function longint sat_acc(longint v);
            longint acc_max;
            acc_max = (64'sd1 <<< (2 * DW - 1)) - 1;
            if (v > acc_max)
                return acc_max;
            if (v < -acc_max - 1)
                return -acc_max - 1;
            return v;
        endfunction

        function void write_reg(pid_caw_pkg::t_cfg_idx idx, logic [DW-1:0] data);
            case (idx)
                pid_caw_pkg::CFG_PROP_GAIN:   kp = data;
                pid_caw_pkg::CFG_DERIV_GAIN:  kd = data;
                pid_caw_pkg::CFG_INTEG_GAIN:  ki = data;
                pid_caw_pkg::CFG_ANTI_WINDUP: windup_guard = data[0];
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [DW-1:0] err, logic signed [DW-1:0] up_lim,
                                 logic signed [DW-1:0] lo_lim);
            longint e, p_t, d_t, total, cl, hi, lo;
            e     = err;
            hi    = up_lim;
            lo    = lo_lim;
            hi    = hi * (64'sd1 <<< FB);
            lo    = lo * (64'sd1 <<< FB);
            p_t   = sat_acc(kp * e);
            d_t   = sat_acc(kd * (e - last_err));
            integ_acc = sat_acc(integ_acc + sat_acc(ki * e));
            total = sat_acc(sat_acc(p_t + d_t) + integ_acc);
            cl    = total;
            if (cl > hi)
                cl = hi;
            if (cl < lo)
                cl = lo;
            if (windup_guard) begin
                integ_acc = sat_acc(sat_acc(cl - p_t) - d_t);
                n_guarded++;
            end
            last_err = e;
            if (cl != total)
                n_clamped++;
            if (lo > hi)
                n_crossed++;
            n_steps++;
            drive_q.push_back(DW'(cl >>> FB));
        endfunction

        function void check_result(logic signed [DW-1:0] got);
            logic signed [DW-1:0] want;
            if (drive_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: drive_out %0d with no step pending", got);
                return;
            end
            want = drive_q.pop_front();
            n_checked++;
            if (got !== want) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("drive_out mismatch on result %0d: expected %0d, got %0d",
                             n_checked, want, got);
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    pid_scoreboard sb = new;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 38);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(pid_caw_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_err_sample, i_upper_limit, i_lower_limit);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_drive_out);
        end
    end

    function automatic logic [DW-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2, 3:    return DW'($urandom_range(0, 511));
            default: return DW'($urandom);
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_err();
        case ($urandom_range(9))
            0:          return {1'b1, {(DW-1){1'b0}}};
            1:          return {1'b0, {(DW-1){1'b1}}};
            2, 3, 4, 5: return DW'(int'($urandom_range(0, 1023)) - 512);
            default:    return DW'($urandom);
        endcase
    endfunction

    task automatic send_step(input logic [DW-1:0] e, input logic [DW-1:0] up,
                             input logic [DW-1:0] lo);
        while (gaps_on && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_err_sample  <= e;
        i_upper_limit <= up;
        i_lower_limit <= lo;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic load_gains(input logic [DW-1:0] kp, input logic [DW-1:0] kd,
                              input logic [DW-1:0] ki, input logic [DW-1:0] aw);
        logic [DW-1:0] vals[4];
        vals = '{kp, kd, ki, aw};
        drain();
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= pid_caw_pkg::t_cfg_idx'(r);
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        logic [DW-1:0] e, a, b, up, lo;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_err_sample  <= '0;
        i_upper_limit <= '0;
        i_lower_limit <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= pid_caw_pkg::CFG_PROP_GAIN;
        i_cfg_data    <= '0;
        gaps_on        = 1'b1;
        n_settings     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // gains still at reset: output is zero pulled into the limits
        send_step(16'd100, 16'd50, -16'sd50);
        send_step(-16'sd5, -16'sd10, -16'sd20);
        send_step(16'd5, 16'd30, 16'd20);

        load_gains(16'h0100, 16'h0080, 16'h0040, 16'h0000);
        send_step(16'h7FFF, 16'h7FFF, 16'h8000);
        send_step(16'h8000, 16'h7FFF, 16'h8000);
        send_step(16'h0000, 16'h7FFF, 16'h8000);
        send_step(16'h0001, 16'h7FFF, 16'h8000);
        send_step(16'hFFFF, 16'h7FFF, 16'h8000);
        send_step(-16'sd3, 16'h7FFF, 16'h8000);
        send_step(16'h0180, 16'h0100, -16'sd256);
        send_step(-16'sd384, 16'h0100, -16'sd256);
        send_step(16'h0000, -16'sd256, 16'h0100);
        send_step(16'd300, 16'd7, 16'd7);

        load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
        send_step(16'h7FFF, 16'h7FFF, 16'h8000);
        send_step(16'h8000, 16'h7FFF, 16'h8000);
        send_step(16'h7FFF, 16'h7FFF, 16'h8000);
        send_step(16'h7FFF, 16'h0200, -16'sd512);
        send_step(16'h0000, 16'h7FFF, 16'h8000);
        send_step(16'h8000, 16'h8000, 16'h7FFF);

        // bit 0 clear, upper bits set: anti-windup off
        load_gains(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFE);
        send_step(16'h7FFF, 16'h7FFF, 16'h8000);
        send_step(16'h7FFF, 16'h7FFF, 16'h8000);
        send_step(16'h8000, 16'h0010, -16'sd16);

        for (int ph = 0; ph < 8; ph++) begin
            load_gains(pick_gain(), pick_gain(), pick_gain(), DW'($urandom));
            gaps_on = !(ph == 3 || ph == 4);
            for (int k = 0; k < 116; k++) begin
                e = pick_err();
                a = DW'($urandom);
                b = DW'($urandom);
                case ($urandom_range(9))
                    0: begin up = a; lo = b; end
                    1: begin up = 16'h7FFF; lo = 16'h8000; end
                    2: begin up = a; lo = a; end
                    3: begin up = DW'($signed(a) >>> 6); lo = DW'($signed(b) >>> 6); end
                    default: begin
                        if ($signed(a) >= $signed(b)) begin
                            up = a;
                            lo = b;
                        end else begin
                            up = b;
                            lo = a;
                        end
                    end
                endcase
                send_step(e, up, lo);
            end
        end
        gaps_on = 1'b1;

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.n_errors++;
            $display("%0d expected results never arrived", sb.pending());
        end

        $display("covered %0d control steps under %0d gain settings, %0d results checked",
                 sb.n_steps, n_settings, sb.n_checked);
        $display("%0d steps clamped, %0d with crossed limits, %0d with anti-windup; %0d errors",
                 sb.n_clamped, sb.n_crossed, sb.n_guarded, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
